// File: hw/rtl/ring_range_write_chunker_assert.svh
// Assertion macros for the ring range write chunker.
`ifndef RING_RANGE_WRITE_CHUNKER_ASSERT_SVH
`define RING_RANGE_WRITE_CHUNKER_ASSERT_SVH

// Same-cycle implication.
`define RRWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rrwc assertion failed");

// Next-cycle implication.
`define RRWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rrwc assertion failed");

`endif

// File: hw/rtl/rrwc_pkg.sv
package rrwc_pkg;

    localparam int ID_W      = 48;
    localparam int RING_W    = 48;
    localparam int OFFSET_W  = 49;
    localparam int COUNT_W   = 17;
    localparam int ERR_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam int ID_WIDTH_DEF = 48;
    localparam int MAX_RUN_DEF  = 63;

    localparam logic [COUNT_W-1:0] CHUNK_LIMIT = 17'd65536;
    localparam logic [COUNT_W-1:0] CHUNK_RESET = 17'd256;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_END_PAST  = 3'd1,
        ERR_BEGIN_OLD = 3'd2,
        ERR_EMPTY     = 3'd3,
        ERR_TOO_LONG  = 3'd4
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_OFFSET  = 2'd0,
        CFG_RING_SIZE    = 2'd1,
        CFG_CHUNK_BLOCKS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_COUNT,
        ST_EMIT,
        ST_FAIL
    } t_state;

endpackage

// File: hw/rtl/rrwc_rem.sv
module rrwc_rem #(
    parameter int IW = rrwc_pkg::ID_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [IW-1:0]               i_dividend,
    input  logic [rrwc_pkg::RING_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rrwc_pkg::RING_W-1:0] o_rem
);

    localparam int DW    = rrwc_pkg::RING_W;
    localparam int CNT_W = $clog2(IW + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]    r_dvd;
    logic [DW-1:0]    r_rem;

    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic [DW-1:0]    n_rem;

    // restoring remainder step: one dividend bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[IW-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_diff[DW-1:0];
        end else begin
            n_rem = w_trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(IW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/ring_range_write_chunker.sv
// Ring range write chunker.
// Slave stream takes one clear request: tdata holds begin_id, end_id,
// oldest_id and latest_id (48 bits each). The request is checked, then
// cut into write commands on the master stream: tdata holds block_offset
// (49 bits) and block_count (17 bits), tuser the error code and tlast
// marks the final command of the request. A rejected request yields one
// command with zero offset and count, the error code and tlast set.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 ring offset, 1 ring size, 2 chunk blocks); write only while idle.
// Sequence: a check state, then the remainder unit forms begin mod ring
// size from the low ID_WIDTH bits of begin (ID_WIDTH at most 48), then a
// counting pass and an emit pass over the n commands. A request that
// fails the checks goes to the error command; one that needs more than
// MAX_RUN commands fails with ERR_TOO_LONG at the end of counting.
// s_axis_tready is high only while idle. A stalled master side holds the
// command in the output register and freezes the emit pass. Reset clears
// the sequencer and the output valid and returns the registers to
// offset 0, size 1, chunk 256.
module ring_range_write_chunker #(
    parameter int ID_WIDTH = rrwc_pkg::ID_WIDTH_DEF,
    parameter int MAX_RUN  = rrwc_pkg::MAX_RUN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // begin_id, end_id, oldest_id, latest_id
    input  logic [4*rrwc_pkg::ID_W-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // block_offset, block_count, zero pad
    output logic [71:0]                    m_axis_tdata,
    output logic                           m_axis_tlast,
    // error_code
    output logic [rrwc_pkg::ERR_W-1:0]     m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [rrwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrwc_pkg::RING_W-1:0]    i_cfg_data
);

    `include "ring_range_write_chunker_assert.svh"

    localparam int FW = rrwc_pkg::ID_W;
    localparam int IW = (ID_WIDTH < FW) ? ID_WIDTH : FW;
    localparam int RW = rrwc_pkg::RING_W;
    localparam int OW = rrwc_pkg::OFFSET_W;
    localparam int KW = rrwc_pkg::COUNT_W;
    localparam int CW = $clog2(MAX_RUN + 1);

    rrwc_pkg::t_state r_state;
    rrwc_pkg::t_state n_state;

    logic [RW-1:0] r_ring_off;
    logic [RW-1:0] r_rsize;
    logic [KW-1:0] r_chunk;

    logic [IW-1:0] r_begin;
    logic [IW-1:0] r_stop;
    logic [IW-1:0] r_oldest;
    logic [IW-1:0] r_latest;
    logic [IW-1:0] r_cur;
    logic [RW-1:0] r_pos;
    logic [RW-1:0] r_pos0;
    logic [CW-1:0] r_ncmd;
    logic [CW-1:0] r_left;
    rrwc_pkg::t_err r_err;

    logic                   r_ovalid;
    logic [OW-1:0]          r_ooff;
    logic [KW-1:0]          r_ocnt;
    logic                   r_olast;
    rrwc_pkg::t_err         r_ouser;

    rrwc_pkg::t_err w_check;
    logic           w_slot;
    logic           w_div_start;
    logic           w_div_done;
    logic [RW-1:0]  w_div_rem;
    logic           w_more;
    logic           w_count_step;
    logic           w_emit;
    logic           w_fail_load;
    logic [RW-1:0]  w_left;
    logic [RW-1:0]  w_to_edge;
    logic [RW-1:0]  w_min;
    logic [KW-1:0]  w_cnt;
    logic [RW:0]    w_pos_sum;
    logic [RW-1:0]  w_pos_next;
    logic [IW-1:0]  w_cur_next;
    logic [RW-1:0]  w_latest;

    // request checks, in priority order
    always_comb begin
        w_latest = RW'(r_latest);
        if (r_begin >= r_stop) begin
            w_check = rrwc_pkg::ERR_EMPTY;
        end else if (r_stop > r_oldest) begin
            w_check = rrwc_pkg::ERR_END_PAST;
        end else if ((r_rsize < w_latest) && (RW'(r_begin) < (w_latest - r_rsize))) begin
            w_check = rrwc_pkg::ERR_BEGIN_OLD;
        end else begin
            w_check = rrwc_pkg::ERR_NONE;
        end
    end

    // chunk step, shared by the counting and emit passes
    always_comb begin
        w_more    = r_cur < r_stop;
        w_left    = RW'(r_stop - r_cur);
        w_to_edge = r_rsize - r_pos;
        w_min     = (w_left < w_to_edge) ? w_left : w_to_edge;
        w_cnt     = (w_min < RW'(r_chunk)) ? w_min[KW-1:0] : r_chunk;
        w_pos_sum = {1'b0, r_pos} + (RW + 1)'(w_cnt);
        w_pos_next = (w_pos_sum == {1'b0, r_rsize}) ? '0 : w_pos_sum[RW-1:0];
        w_cur_next = r_cur + IW'(w_cnt);
    end

    rrwc_rem #(
        .IW(IW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_begin),
        .i_divisor  (r_rsize),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrwc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = rrwc_pkg::ST_CHECK;
                end
            end
            rrwc_pkg::ST_CHECK: begin
                if (w_check != rrwc_pkg::ERR_NONE) begin
                    n_state = rrwc_pkg::ST_FAIL;
                end else begin
                    n_state = rrwc_pkg::ST_DIV;
                end
            end
            rrwc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = rrwc_pkg::ST_COUNT;
                end
            end
            rrwc_pkg::ST_COUNT: begin
                if (!(w_more && (r_ncmd < CW'(MAX_RUN)))) begin
                    n_state = w_more ? rrwc_pkg::ST_FAIL : rrwc_pkg::ST_EMIT;
                end
            end
            rrwc_pkg::ST_EMIT: begin
                if (w_slot && (r_left == CW'(1))) begin
                    n_state = rrwc_pkg::ST_IDLE;
                end
            end
            rrwc_pkg::ST_FAIL: begin
                if (w_slot) begin
                    n_state = rrwc_pkg::ST_IDLE;
                end
            end
            default: n_state = rrwc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_slot       = !r_ovalid || m_axis_tready;
        w_div_start  = (r_state == rrwc_pkg::ST_CHECK) && (w_check == rrwc_pkg::ERR_NONE);
        w_count_step = (r_state == rrwc_pkg::ST_COUNT) && w_more && (r_ncmd < CW'(MAX_RUN));
        w_emit       = (r_state == rrwc_pkg::ST_EMIT) && w_slot;
        w_fail_load  = (r_state == rrwc_pkg::ST_FAIL) && w_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rrwc_pkg::ST_IDLE;
            r_ovalid   <= 1'b0;
            r_ring_off <= '0;
            r_rsize    <= RW'(1);
            r_chunk    <= rrwc_pkg::CHUNK_RESET;
        end else begin
            r_state <= n_state;
            if (w_emit || w_fail_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrwc_pkg::CFG_RING_OFFSET: r_ring_off <= i_cfg_data;
                    rrwc_pkg::CFG_RING_SIZE: begin
                        r_rsize <= (i_cfg_data == '0) ? RW'(1) : i_cfg_data;
                    end
                    rrwc_pkg::CFG_CHUNK_BLOCKS: begin
                        if (i_cfg_data[KW-1:0] == '0) begin
                            r_chunk <= KW'(1);
                        end else if (i_cfg_data[KW-1:0] > rrwc_pkg::CHUNK_LIMIT) begin
                            r_chunk <= rrwc_pkg::CHUNK_LIMIT;
                        end else begin
                            r_chunk <= i_cfg_data[KW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_begin  <= s_axis_tdata[IW-1:0];
            r_stop   <= s_axis_tdata[FW+IW-1:FW];
            r_oldest <= s_axis_tdata[2*FW+IW-1:2*FW];
            r_latest <= s_axis_tdata[3*FW+IW-1:3*FW];
        end
        if (r_state == rrwc_pkg::ST_CHECK) begin
            r_err <= w_check;
        end
        if (w_div_done) begin
            r_pos0 <= w_div_rem;
            r_pos  <= w_div_rem;
            r_cur  <= r_begin;
            r_ncmd <= '0;
        end else if (w_count_step || w_emit) begin
            r_pos <= w_pos_next;
            r_cur <= w_cur_next;
        end
        if (w_count_step) begin
            r_ncmd <= r_ncmd + 1'b1;
        end
        // end of counting pass: rewind for the emit pass
        if ((r_state == rrwc_pkg::ST_COUNT) && !w_count_step) begin
            r_pos  <= r_pos0;
            r_cur  <= r_begin;
            r_left <= r_ncmd;
            if (w_more) begin
                r_err <= rrwc_pkg::ERR_TOO_LONG;
            end
        end
        if (w_emit) begin
            r_left  <= r_left - 1'b1;
            r_ooff  <= OW'(r_pos) + OW'(r_ring_off);
            r_ocnt  <= w_cnt;
            r_olast <= (r_left == CW'(1));
            r_ouser <= rrwc_pkg::ERR_NONE;
        end else if (w_fail_load) begin
            r_ooff  <= '0;
            r_ocnt  <= '0;
            r_olast <= 1'b1;
            r_ouser <= r_err;
        end
    end

    assign s_axis_tready = i_rst_n && (r_state == rrwc_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ocnt, r_ooff};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    `RRWC_ASSERT_NOW(a_err_single, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != rrwc_pkg::ERR_NONE),
        (r_ocnt == '0) && (r_ooff == '0) && m_axis_tlast)
    `RRWC_ASSERT_NOW(a_cmd_count, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == rrwc_pkg::ERR_NONE),
        (r_ocnt != '0) && (r_ocnt <= r_chunk))
    `RRWC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready)

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrwc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [ID_W-1:0]      ID_MAX        = '1;
    localparam longint unsigned      MEBI          = 1048576;
    localparam int                   CYCLE_LIMIT   = 1_500_000;
    localparam int                   TAIL_CYCLES   = 150;

    typedef struct packed {
        logic [OFFSET_W-1:0] block_offset;
        logic [COUNT_W-1:0]  block_count;
        t_err                error_code;
        logic                last;
    } write_cmd_t;

    class clear_run_tracker;
        logic [RING_W-1:0]  ring_offset_q;
        logic [RING_W-1:0]  ring_size_q;
        logic [COUNT_W-1:0] chunk_q;
        write_cmd_t         due_cmds[$];
        int                 failures;

        function new();
            ring_offset_q = '0;
            ring_size_q   = 48'd1;
            chunk_q       = CHUNK_RESET;
            failures      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [RING_W-1:0] value);
            case (idx)
                CFG_RING_OFFSET:  ring_offset_q = value;
                CFG_RING_SIZE:    ring_size_q   = value;
                CFG_CHUNK_BLOCKS: chunk_q       = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_reject(t_err code);
            write_cmd_t cmd;
            cmd.block_offset = '0;
            cmd.block_count  = '0;
            cmd.error_code   = code;
            cmd.last         = 1'b1;
            due_cmds.push_back(cmd);
        endfunction

        function void add_request(logic [ID_W-1:0] first_id, logic [ID_W-1:0] stop_id,
                                  logic [ID_W-1:0] oldest_id, logic [ID_W-1:0] latest_id);
            logic [ID_W-1:0]    rsize;
            logic [ID_W-1:0]    cur;
            logic [ID_W-1:0]    pos;
            logic [ID_W-1:0]    left;
            logic [ID_W-1:0]    cnt;
            logic [COUNT_W-1:0] chunk;
            write_cmd_t         run[$];
            write_cmd_t         cmd;
            int                 n;
            rsize = (ring_size_q == '0) ? 48'd1 : ring_size_q;
            chunk = (chunk_q == '0) ? 17'd1 : ((chunk_q > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_q);
            if (first_id >= stop_id) begin
                push_reject(ERR_EMPTY);
            end else if (stop_id > oldest_id) begin
                push_reject(ERR_END_PAST);
            end else if (rsize < latest_id && first_id < latest_id - rsize) begin
                push_reject(ERR_BEGIN_OLD);
            end else begin
                cur = first_id;
                n   = 0;
                while (cur < stop_id && n < MAX_RUN_DEF) begin
                    pos  = cur % rsize;
                    left = stop_id - cur;
                    cnt  = (left < rsize - pos) ? left : rsize - pos;
                    if (chunk < cnt)
                        cnt = chunk;
                    cmd.block_offset = {1'b0, pos} + {1'b0, ring_offset_q};
                    cmd.block_count  = cnt[COUNT_W-1:0];
                    cmd.error_code   = ERR_NONE;
                    cmd.last         = 1'b0;
                    run.push_back(cmd);
                    cur = cur + cnt;
                    n++;
                end
                if (cur < stop_id) begin
                    push_reject(ERR_TOO_LONG);
                end else begin
                    run[run.size()-1].last = 1'b1;
                    foreach (run[i])
                        due_cmds.push_back(run[i]);
                end
            end
        endfunction

        function void match_command(write_cmd_t got);
            write_cmd_t want;
            if (due_cmds.size() == 0) begin
                $error("unexpected write command: offset %0h count %0d error %0d last %0b",
                       got.block_offset, got.block_count, got.error_code, got.last);
                failures++;
                return;
            end
            want = due_cmds.pop_front();
            if (got.block_offset !== want.block_offset) begin
                $error("block_offset: expected %0h, got %0h", want.block_offset, got.block_offset);
                failures++;
            end
            if (got.block_count !== want.block_count) begin
                $error("block_count: expected %0d, got %0d", want.block_count, got.block_count);
                failures++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
        endfunction

        function int pending();
            return due_cmds.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [4*ID_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [71:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic [ERR_W-1:0]     m_axis_tuser;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [RING_W-1:0]    i_cfg_data    = '0;

    clear_run_tracker board;
    int               tx_idle_pct     = 0;
    int               rx_stall_pct    = 0;
    int               hold_cycles_req = 0;
    int               hold_left       = 0;
    int unsigned      cycle_count     = 0;

    ring_range_write_chunker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.add_request(s_axis_tdata[ID_W-1:0], s_axis_tdata[2*ID_W-1:ID_W],
                                  s_axis_tdata[3*ID_W-1:2*ID_W], s_axis_tdata[4*ID_W-1:3*ID_W]);
            if (m_axis_tvalid && m_axis_tready)
                board.match_command(write_cmd_t'({m_axis_tdata[48:0], m_axis_tdata[65:49],
                                                  m_axis_tuser, m_axis_tlast}));
        end
    end

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RING_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic [ID_W-1:0] first_id, input logic [ID_W-1:0] stop_id,
                                input logic [ID_W-1:0] oldest_id,
                                input logic [ID_W-1:0] latest_id, input bit drain_after);
        s_axis_tdata  <= {latest_id, oldest_id, stop_id, first_id};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (drain_after) begin
            wait_drained();
        end else if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_random(input bit drain_after);
        longint unsigned rsize;
        longint unsigned unit;
        longint unsigned span;
        longint unsigned len;
        longint unsigned first_id;
        longint unsigned stop_id;
        longint unsigned oldest_id;
        longint unsigned latest_id;
        int unsigned     back;
        rsize = (board.ring_size_q == '0) ? 1 : board.ring_size_q;
        unit  = (board.chunk_q == '0) ? 1 : board.chunk_q;
        if (unit > rsize)
            unit = rsize;
        case ($urandom_range(9))
            0, 1, 2, 3: span = unit * 4;
            4, 5, 6:    span = unit * 24;
            7:          span = unit * 70;
            default:    span = 8;
        endcase
        len = 1 + rand64() % span;
        case ($urandom_range(3))
            0:       first_id = rand64();
            1:       first_id = rsize * $urandom_range(1, 3) - $urandom_range(0, 3);
            default: first_id = $urandom_range(0, 1 << 20);
        endcase
        first_id = first_id & ID_MAX;
        if (first_id > ID_MAX - len - 8)
            first_id = ID_MAX - len - 8;
        stop_id   = first_id + len;
        oldest_id = stop_id + $urandom_range(0, 2);
        case ($urandom_range(3))
            0:       latest_id = first_id / $urandom_range(1, 4);
            1:       latest_id = first_id + rsize;
            default: latest_id = first_id + rand64() % (rsize + 1);
        endcase
        if (latest_id > ID_MAX)
            latest_id = ID_MAX;
        // broken requests and noise
        case ($urandom_range(9))
            0: begin
                first_id  = rand64() & ID_MAX;
                stop_id   = rand64() & ID_MAX;
                oldest_id = rand64() & ID_MAX;
                latest_id = rand64() & ID_MAX;
            end
            1: begin
                back = $urandom_range(0, 3);
                stop_id = (back > first_id) ? 0 : first_id - back;
            end
            2: begin
                back = $urandom_range(1, 3);
                oldest_id = (back > stop_id) ? 0 : stop_id - back;
            end
            3: begin
                latest_id = first_id + rsize + 1 + $urandom_range(0, 100);
                if (latest_id > ID_MAX)
                    latest_id = ID_MAX;
            end
            default: ;
        endcase
        send_request(first_id[ID_W-1:0], stop_id[ID_W-1:0], oldest_id[ID_W-1:0],
                     latest_id[ID_W-1:0], drain_after);
    endtask

    task automatic run_phase(input logic [RING_W-1:0] offset, input logic [RING_W-1:0] size,
                             input logic [COUNT_W-1:0] chunk, input int tx_pct, input int rx_pct,
                             input int items, input int hold_cycles, input int pause_at);
        write_reg(CFG_RING_OFFSET, offset);
        write_reg(CFG_RING_SIZE, size);
        write_reg(CFG_CHUNK_BLOCKS, RING_W'(chunk));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold_cycles != 0)
            hold_cycles_req = hold_cycles;
        for (int i = 0; i < items; i++)
            send_random(i == pause_at);
        wait_drained();
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: offset 0, ring of one block, chunk 256
        send_request(0, 1, 1, 0, 0);
        send_request(10, 73, 100, 11, 0);
        send_request(10, 74, 100, 11, 0);
        wait_drained();

        write_reg(CFG_RING_OFFSET, ID_MAX);
        write_reg(CFG_RING_SIZE, 1000);
        write_reg(CFG_CHUNK_BLOCKS, 100);
        send_request(990, 1010, 2000, 1500, 0);
        send_request(5, 5, 5, 5, 0);
        send_request(ID_MAX, 0, 0, 0, 0);
        send_request(0, 10, 9, 0, 0);
        send_request(999, 1010, 2000, 2000, 0);
        send_request(1000, 1001, 1001, 2000, 0);
        send_request(0, 1, 1, 1000, 0);
        send_request(ID_MAX - 1, ID_MAX, ID_MAX, ID_MAX, 0);
        send_request(0, 0, 0, 0, 0);
        send_request(0, 5000, 5000, 0, 0);
        wait_drained();

        // zero ring size and zero chunk both act as one
        write_reg(CFG_RING_SIZE, 0);
        write_reg(CFG_CHUNK_BLOCKS, 0);
        send_request(5, 8, 8, 5, 0);
        send_request(0, 1, 1, 2, 0);
        wait_drained();

        // oversized chunk saturates
        write_reg(CFG_RING_OFFSET, 0);
        write_reg(CFG_RING_SIZE, ID_MAX);
        write_reg(CFG_CHUNK_BLOCKS, RING_W'(17'h1FFFF));
        send_request(0, 200000, ID_MAX, 0, 0);
        send_request(ID_MAX - 100000, ID_MAX, ID_MAX, ID_MAX, 0);
        wait_drained();

        write_reg(CFG_RING_SIZE, 48'h8000_0000_0000);
        write_reg(CFG_CHUNK_BLOCKS, RING_W'(CHUNK_LIMIT));
        write_reg(CFG_IDX_SPARE, ID_MAX);
        send_request(48'h7FFF_FFFF_FFFD, 48'h8000_0000_0005, 48'h8000_0000_0005,
                     48'h8000_0000_0000, 0);
        send_request(0, 65536 * 63, ID_MAX, 0, 0);
        send_request(0, 65536 * 63 + 1, ID_MAX, 0, 0);
        wait_drained();

        run_phase(ID_W'(rand64()), 1000, 64, 0, 0, 44, 0, -1);
        run_phase(0, 1, 256, 55, 0, 44, 0, -1);
        run_phase(ID_MAX, ID_MAX, CHUNK_LIMIT, 0, 55, 44, 0, -1);
        run_phase(ID_W'(rand64()), 37, 5, 19, 19, 44, 0, -1);
        run_phase(ID_W'(rand64()), ID_W'(rand64()), COUNT_W'($urandom), 0, 0, 44, 400, -1);
        run_phase(12345, 4096, 1, 55, 0, 44, 0, 20);
        run_phase(ID_W'(rand64()), MEBI, 256, 0, 55, 44, 0, -1);
        run_phase(ID_W'(rand64()), $urandom_range(1, 5000), COUNT_W'($urandom), 19, 19, 44, 0,
                  -1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rrwc_pkg.sv
hw/rtl/rrwc_rem.sv
hw/rtl/ring_range_write_chunker.sv
dv/testbench.sv
